// ===== rtl/core/bhd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhd_pkg
// Shared types and constants of the BMP height decoder.
// ----------------------------------------------------------------------------
package bhd_pkg;

  localparam int unsigned COL_W      = 12;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned RAW_W      = 8;
  localparam int unsigned Q16_W      = 16;
  localparam int unsigned ST_W       = 3;
  localparam int unsigned DIMF_W     = 13;
  localparam int unsigned OUT_DATA_W = 96;
  localparam int unsigned PAL_DEPTH  = 256;
  localparam int unsigned PAL_AW     = 8;

  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_HDR    = 3'd1;
  localparam logic [ST_W-1:0] ST_COMPRESSED = 3'd2;
  localparam logic [ST_W-1:0] ST_BAD_DIMS   = 3'd3;
  localparam logic [ST_W-1:0] ST_BAD_BPP    = 3'd4;
  localparam logic [ST_W-1:0] ST_TRUNC      = 3'd5;

  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;

  localparam logic [31:0] OFF_SIG0   = 32'd0;
  localparam logic [31:0] OFF_SIG1   = 32'd1;
  localparam logic [31:0] OFF_PDO    = 32'd10;
  localparam logic [31:0] OFF_IHS    = 32'd14;
  localparam logic [31:0] OFF_WIDTH  = 32'd18;
  localparam logic [31:0] OFF_HEIGHT = 32'd22;
  localparam logic [31:0] OFF_BPP    = 32'd28;
  localparam logic [31:0] OFF_COMP   = 32'd30;
  localparam logic [31:0] OFF_CHECK  = 32'd53;
  localparam logic [31:0] HDR_LEN    = 32'd54;
  localparam logic [31:0] PAL_BASE   = 32'd14;
  localparam logic [31:0] OFF_MAX    = 32'hFFFF_FFFF;

  localparam logic [15:0] BPP_8  = 16'd8;
  localparam logic [15:0] BPP_24 = 16'd24;
  localparam logic [15:0] BPP_32 = 16'd32;

  localparam logic [2:0] BPX_1 = 3'd1;
  localparam logic [2:0] BPX_3 = 3'd3;
  localparam logic [2:0] BPX_4 = 3'd4;

  typedef struct packed {
    logic              pix_v;
    logic              sum_v;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [RAW_W-1:0]  raw;
    logic              use_pal;
    logic [ST_W-1:0]   st;
    logic [DIMF_W-1:0] w;
    logic [DIMF_W-1:0] h;
  } bhd_evt_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
    logic [RAW_W-1:0]  data;
  } bhd_pal_wr_t;

  typedef struct packed {
    logic              is_summary;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [RAW_W-1:0]  raw;
    logic [ST_W-1:0]   st;
    logic [RAW_W-1:0]  mn;
    logic [RAW_W-1:0]  mx;
    logic [DIMF_W-1:0] w;
    logic [DIMF_W-1:0] h;
  } bhd_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/bhd_palette.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhd_palette
// Palette red memory, 256 x 8, one write and one registered read per cycle,
// with per-entry valid flags that clear at once.
// ----------------------------------------------------------------------------
module bhd_palette
  import bhd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              clr,
  input  wire bhd_pal_wr_t       wr,
  input  wire logic              rd_en,
  input  wire logic [PAL_AW-1:0] rd_addr,
  output logic      [RAW_W-1:0]  rd_data,
  output logic                   rd_hit
);

  logic [RAW_W-1:0]     mem [PAL_DEPTH];
  logic [PAL_DEPTH-1:0] vld_r;
  logic [RAW_W-1:0]     rd_data_r;
  logic                 rd_hit_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_hit_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;
  assign rd_hit  = rd_hit_r;

`ifndef NO_ASSERTIONS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr.en && rd_en))
    else $error("Palette written and read by the same beat.");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/bhd_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhd_parse
// Header field capture, header check, palette capture and the pixel walk
// over rows with padding skip. Produces one event record per byte.
// ----------------------------------------------------------------------------
module bhd_parse
  import bhd_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_acc,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output bhd_evt_t         evt,
  output bhd_pal_wr_t      pal_wr,
  output logic             pal_clr
);

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned BIR_W = DIM_W + 2;
  localparam logic [1:0]  K_PAL = 2'd0;
  localparam logic [1:0]  K_RED = 2'd2;

  function automatic logic [31:0] put_byte(input logic [31:0] f, input logic [1:0] lane,
                                           input logic [7:0] b);
    put_byte = f | (32'(b) << {lane, 3'b000});
  endfunction

  logic [31:0]      off_r, off_nxt;
  logic [31:0]      pdo_r, pdo_nxt;
  logic [31:0]      ihs_r, ihs_nxt;
  logic [32:0]      start_r, start_nxt;
  logic [31:0]      width_r, width_nxt;
  logic [31:0]      height_r, height_nxt;
  logic [15:0]      bpp_r, bpp_nxt;
  logic             comp_r, comp_nxt;
  logic [ST_W-1:0]  err_r, err_nxt;
  logic [DIM_W-1:0] hmag_r, hmag_nxt;
  logic [2:0]       bpx_r, bpx_nxt;
  logic [BIR_W-1:0] payload_r, payload_nxt;
  logic [BIR_W-1:0] rowlen_r, rowlen_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [BIR_W-1:0] bir_r, bir_nxt;
  logic [1:0]       k_r, k_nxt;

  logic [31:0]      h32;
  logic [DIM_W-1:0] wd;
  logic [32:0]      rel;
  logic [BIR_W-1:0] bir_inc;
  logic [1:0]       k_tgt;
  logic [ST_W-1:0]  st;

  always_comb begin
    off_nxt     = (off_r == OFF_MAX) ? off_r : off_r + 32'd1;
    pdo_nxt     = pdo_r;
    ihs_nxt     = ihs_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    bpp_nxt     = bpp_r;
    comp_nxt    = comp_r;
    err_nxt     = err_r;
    hmag_nxt    = hmag_r;
    bpx_nxt     = bpx_r;
    payload_nxt = payload_r;
    rowlen_nxt  = rowlen_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    bir_nxt     = bir_r;
    k_nxt       = k_r;
    evt         = '0;
    pal_wr      = '0;
    h32         = height_r[31] ? (32'd0 - height_r) : height_r;
    wd          = DIM_W'(width_r);
    bir_inc     = bir_r + BIR_W'(1);
    k_tgt       = (bpx_r == BPX_1) ? K_PAL : K_RED;
    rel         = {1'b0, off_r} - start_r;

    if (off_r == OFF_SIG0 && in_byte != SIG_B && err_r == ST_OK) begin
      err_nxt = ST_BAD_HDR;
    end
    if (off_r == OFF_SIG1 && in_byte != SIG_M && err_r == ST_OK) begin
      err_nxt = ST_BAD_HDR;
    end
    if (off_r >= OFF_PDO && off_r <= OFF_PDO + 32'd3) begin
      pdo_nxt = put_byte(pdo_r, 2'(off_r[1:0] - 2'(OFF_PDO)), in_byte);
    end
    if (off_r >= OFF_IHS && off_r <= OFF_IHS + 32'd3) begin
      ihs_nxt = put_byte(ihs_r, 2'(off_r[1:0] - 2'(OFF_IHS)), in_byte);
    end
    if (off_r >= OFF_WIDTH && off_r <= OFF_WIDTH + 32'd3) begin
      width_nxt = put_byte(width_r, 2'(off_r[1:0] - 2'(OFF_WIDTH)), in_byte);
    end
    if (off_r >= OFF_HEIGHT && off_r <= OFF_HEIGHT + 32'd3) begin
      height_nxt = put_byte(height_r, 2'(off_r[1:0] - 2'(OFF_HEIGHT)), in_byte);
    end
    if (off_r >= OFF_BPP && off_r <= OFF_BPP + 32'd1) begin
      bpp_nxt = bpp_r | (16'(in_byte) << {off_r[0], 3'b000});
    end
    if (off_r >= OFF_COMP && off_r <= OFF_COMP + 32'd3 && in_byte != 8'd0) begin
      comp_nxt = 1'b1;
    end
    start_nxt = {1'b0, ihs_nxt} + 33'(PAL_BASE);

    if (off_r >= OFF_WIDTH && off_r < pdo_r && !rel[32] && rel[1:0] == 2'd2 &&
        rel[32:10] == '0) begin
      pal_wr.en   = in_acc;
      pal_wr.addr = rel[9:2];
      pal_wr.data = in_byte;
    end

    if (off_r == OFF_CHECK) begin
      if (err_r == ST_OK) begin
        if (pdo_r < HDR_LEN) begin
          err_nxt = ST_BAD_HDR;
        end else if (comp_r) begin
          err_nxt = ST_COMPRESSED;
        end else if (width_r == 32'd0 || width_r[31] || width_r > 32'(MAX_DIM) ||
                     h32 == 32'd0 || h32 > 32'(MAX_DIM)) begin
          err_nxt = ST_BAD_DIMS;
        end else if (bpp_r != BPP_8 && bpp_r != BPP_24 && bpp_r != BPP_32) begin
          err_nxt = ST_BAD_BPP;
        end
      end
      hmag_nxt = DIM_W'(h32);
      case (bpp_r)
        BPP_8: begin
          bpx_nxt     = BPX_1;
          payload_nxt = BIR_W'(wd);
        end
        BPP_24: begin
          bpx_nxt     = BPX_3;
          payload_nxt = BIR_W'(wd) + (BIR_W'(wd) << 1);
        end
        default: begin
          bpx_nxt     = BPX_4;
          payload_nxt = BIR_W'(wd) << 2;
        end
      endcase
      rowlen_nxt = (payload_nxt + BIR_W'(3)) & ~BIR_W'(3);
    end else if (err_r == ST_OK && off_r >= HDR_LEN && off_r >= pdo_r &&
                 row_r < hmag_r) begin
      if (bir_r < payload_r) begin
        if (k_r == k_tgt) begin
          evt.pix_v   = 1'b1;
          evt.col     = COL_W'(col_r);
          evt.row     = height_r[31] ? ROW_W'(row_r)
                                     : ROW_W'(hmag_r - DIM_W'(1) - row_r);
          evt.raw     = in_byte;
          evt.use_pal = (bpx_r == BPX_1);
        end
        if (k_r == 2'(bpx_r - BPX_1)) begin
          k_nxt   = 2'd0;
          col_nxt = col_r + DIM_W'(1);
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      if (bir_inc >= rowlen_r) begin
        bir_nxt = '0;
        col_nxt = '0;
        k_nxt   = 2'd0;
        row_nxt = row_r + DIM_W'(1);
      end else begin
        bir_nxt = bir_inc;
      end
    end

    if (err_nxt != ST_OK) begin
      st = err_nxt;
    end else if (off_r < OFF_CHECK) begin
      st = ST_BAD_HDR;
    end else if (row_nxt < hmag_nxt) begin
      st = ST_TRUNC;
    end else begin
      st = ST_OK;
    end
    evt.sum_v = in_last;
    if (in_last) begin
      evt.st = st;
      if (st == ST_OK || st == ST_TRUNC) begin
        evt.w = width_r[DIMF_W-1:0];
        evt.h = DIMF_W'(hmag_nxt);
      end
    end
  end

  assign pal_clr = in_acc && in_last;

  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && in_last)) begin
      off_r    <= '0;
      pdo_r    <= '0;
      ihs_r    <= '0;
      start_r  <= 33'(PAL_BASE);
      width_r  <= '0;
      height_r <= '0;
      bpp_r    <= '0;
      comp_r   <= 1'b0;
      err_r    <= ST_OK;
      col_r    <= '0;
      row_r    <= '0;
      bir_r    <= '0;
      k_r      <= 2'd0;
    end else if (in_acc) begin
      off_r    <= off_nxt;
      pdo_r    <= pdo_nxt;
      ihs_r    <= ihs_nxt;
      start_r  <= start_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      bpp_r    <= bpp_nxt;
      comp_r   <= comp_nxt;
      err_r    <= err_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      bir_r    <= bir_nxt;
      k_r      <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hmag_r    <= hmag_nxt;
      bpx_r     <= bpx_nxt;
      payload_r <= payload_nxt;
      rowlen_r  <= rowlen_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_pixel_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    evt.pix_v |-> (err_r == ST_OK && off_r >= pdo_r && pdo_r >= HDR_LEN))
    else $error("Pixel event outside the checked pixel data.");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/bhd_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhd_emit
// Result stage: palette lookup merge, min/max tracking, summary build and a
// two-entry output queue.
// ----------------------------------------------------------------------------
module bhd_emit
  import bhd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_acc,
  input  wire bhd_evt_t         evt,
  output logic                  in_rdy,
  input  wire logic [RAW_W-1:0] pal_data,
  input  wire logic             pal_hit,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output bhd_res_t              out_res
);

  localparam logic [RAW_W-1:0] MIN_INIT = 8'hFF;
  localparam logic [RAW_W-1:0] MAX_INIT = 8'h00;

  bhd_evt_t         s1_r;
  logic             s1_pix_r;
  logic             s1_sum_r;
  logic [RAW_W-1:0] min_r;
  logic [RAW_W-1:0] max_r;
  bhd_res_t         fifo_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r, cnt_nxt;

  logic [RAW_W-1:0] v;
  logic             pop;
  logic             push;
  bhd_res_t         push_res;

  always_comb begin
    v        = (s1_r.use_pal && pal_hit) ? pal_data : s1_r.raw;
    pop      = out_valid && out_ready;
    push     = (s1_pix_r || s1_sum_r) && ((cnt_r != 2'd2) || pop);
    in_rdy   = !(s1_pix_r || s1_sum_r) || (push && !(s1_pix_r && s1_sum_r));
    push_res = '0;
    if (s1_pix_r) begin
      push_res.col = s1_r.col;
      push_res.row = s1_r.row;
      push_res.raw = v;
    end else begin
      push_res.is_summary = 1'b1;
      push_res.st         = s1_r.st;
      push_res.w          = s1_r.w;
      push_res.h          = s1_r.h;
      if (s1_r.st == ST_OK) begin
        push_res.mn = min_r;
        push_res.mx = max_r;
      end
    end
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= evt;
    end
    if (push) begin
      fifo_r[wr_ptr_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_pix_r <= 1'b0;
      s1_sum_r <= 1'b0;
      min_r    <= MIN_INIT;
      max_r    <= MAX_INIT;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (in_acc) begin
        s1_pix_r <= evt.pix_v;
        s1_sum_r <= evt.sum_v;
      end else if (push) begin
        if (s1_pix_r) begin
          s1_pix_r <= 1'b0;
        end else begin
          s1_sum_r <= 1'b0;
        end
      end
      if (push && s1_pix_r) begin
        if (v < min_r) begin
          min_r <= v;
        end
        if (v > max_r) begin
          max_r <= v;
        end
      end else if (push) begin
        min_r <= MIN_INIT;
        max_r <= MAX_INIT;
      end
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = fifo_r[rd_ptr_r];

`ifndef NO_ASSERTIONS
  a_no_accept_two_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !(s1_pix_r && s1_sum_r))
    else $error("Beat accepted while a pixel and a summary are pending.");

  a_summary_follows_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (push && s1_pix_r && s1_sum_r) |=> (s1_sum_r && !s1_pix_r))
    else $error("Summary lost after its pixel was queued.");

  a_stats_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !s1_pix_r) |=> (min_r == MIN_INIT && max_r == MAX_INIT))
    else $error("Min/max not restarted after a summary.");

  a_queue_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("Output queue overfilled.");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/bmp_height_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_height_decoder
// Uncompressed BMP stream decoder producing per-pixel height results and an
// end-of-file summary.
// ----------------------------------------------------------------------------
// The decoder takes one file byte per beat and sustains one beat per cycle
// while the output is not stalled. A pixel result passes through the stage
// register and the output queue. A last byte that also completes a pixel puts
// two results into the output stage, which holds the input until the summary
// is queued. Palette red values live in a 256 x 8 synchronous memory with one
// registered read port; its valid flags clear at once at reset and at the end
// of each file, so no clearing pass is needed. Pixels delivered before a
// truncated status must be discarded by the consumer.
module bmp_height_decoder
  import bhd_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // data_byte[7:0]
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // col[11:0], out_row[23:12], raw_height[31:24], height_q16[47:32],
  // status[50:48], min_height[58:51], max_height[66:59],
  // image_width[79:67], image_height[92:80], zero[95:93]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast
);

  logic        in_acc;
  bhd_evt_t    evt;
  bhd_pal_wr_t pal_wr;
  logic        pal_clr;
  logic        pal_rd_en;
  logic [RAW_W-1:0] pal_data;
  logic        pal_hit;
  bhd_res_t    res;

  assign in_acc    = in_tvalid && in_tready;
  assign pal_rd_en = in_acc && evt.pix_v && evt.use_pal;

  bhd_parse #(
    .MAX_DIM (MAX_DIM)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .evt     (evt),
    .pal_wr  (pal_wr),
    .pal_clr (pal_clr)
  );

  bhd_palette u_palette (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (pal_clr),
    .wr      (pal_wr),
    .rd_en   (pal_rd_en),
    .rd_addr (evt.raw),
    .rd_data (pal_data),
    .rd_hit  (pal_hit)
  );

  bhd_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .evt       (evt),
    .in_rdy    (in_tready),
    .pal_data  (pal_data),
    .pal_hit   (pal_hit),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tlast = res.is_summary;
  assign out_tdata = {3'b000, res.h, res.w, res.mx, res.mn, res.st,
                      res.raw, res.raw, res.raw, res.row, res.col};

endmodule
`default_nettype wire
